// File: hw/rtl/dpsm_pkg.sv
// Package for the dual pattern stream matcher.
// Holds widths, action and outcome codes, register indexes, shared types and a length clamp.
// No dependencies.
`timescale 1ns / 1ps

package dpsm_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int BYTE_W            = 8;
  localparam int PAT_W             = 64;
  localparam int LEN_W             = 4;
  localparam int POS_IDX_W         = $clog2(MAX_PATTERN_BYTES);
  localparam int TICK_W            = 32;
  localparam int ELAPSED_W         = TICK_W + 1;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OUT_FIRST   = 2'd0,
    OUT_SECOND  = 2'd1,
    OUT_TIMEOUT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_PATTERN  = 3'd0,
    REG_FIRST_LENGTH   = 3'd1,
    REG_SECOND_PATTERN = 3'd2,
    REG_SECOND_LENGTH  = 3'd3,
    REG_TIMEOUT_TICKS  = 3'd4
  } reg_idx_t;

  // Control from the top level to one pattern tracker
  typedef struct packed {
    logic step;   // a byte is processed this cycle
    logic clear;  // drop progress (start or end of search)
  } match_ctl_t;

  // Saturate a length field to the pattern capacity
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len > LEN_W'(MAX_PATTERN_BYTES)) begin
      res = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/dpsm_ifs.sv
// Channel interfaces for the dual pattern stream matcher.
// Depends on dpsm_pkg for payload widths.
`timescale 1ns / 1ps

interface dpsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [dpsm_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface dpsm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  modport source (output valid, output outcome, input ready);
  modport sink   (input valid, input outcome, output ready);
endinterface

interface dpsm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpsm_pkg::CFG_IDX_W-1:0]  index;
  logic [dpsm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dpsm_tracker.sv
// Match position tracker for one pattern.
// Depends on dpsm_pkg.
`timescale 1ns / 1ps

module dpsm_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpsm_pkg::match_ctl_t          ctl,
  input  logic [dpsm_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [dpsm_pkg::PAT_W-1:0]    pattern,
  input  logic [dpsm_pkg::LEN_W-1:0]    length,   // already clamped
  output logic                          hit
);

  logic [dpsm_pkg::LEN_W-1:0]     pos_r;
  logic [dpsm_pkg::LEN_W-1:0]     pos_nxt;
  logic [dpsm_pkg::LEN_W-1:0]     pos_base;
  logic [dpsm_pkg::LEN_W-1:0]     pos_adv;
  logic [dpsm_pkg::POS_IDX_W-1:0] idx;
  logic [dpsm_pkg::BYTE_W-1:0]    exp_byte;
  logic [dpsm_pkg::BYTE_W-1:0]    head_byte;
  logic                           disabled;

  // Compare the byte at the current position, fall back to the head byte
  always_comb begin
    disabled  = (length == '0);
    pos_base  = (pos_r >= length) ? '0 : pos_r;
    idx       = pos_base[dpsm_pkg::POS_IDX_W-1:0];
    exp_byte  = pattern[idx*dpsm_pkg::BYTE_W +: dpsm_pkg::BYTE_W];
    head_byte = pattern[dpsm_pkg::BYTE_W-1:0];
    if (rx_byte == exp_byte) begin
      pos_adv = pos_base + dpsm_pkg::LEN_W'(1);
    end else if (rx_byte == head_byte) begin
      pos_adv = dpsm_pkg::LEN_W'(1);
    end else begin
      pos_adv = '0;
    end
    hit = ctl.step && !disabled && (pos_adv >= length);
  end

  // Advance on a processed byte, drop on start or end of search
  always_comb begin
    pos_nxt = pos_r;
    if (ctl.clear) begin
      pos_nxt = '0;
    end else if (ctl.step && !disabled) begin
      pos_nxt = pos_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: hw/rtl/dual_pattern_stream_matcher.sv
// Top level of the dual pattern stream matcher.
// Depends on dpsm_pkg, the channel interfaces in dpsm_ifs and dpsm_tracker.
`timescale 1ns / 1ps

// Usage:
//   in_if  : items of (action, rx_byte). Start arms a search and clears
//            progress and elapsed ticks; byte items advance both patterns;
//            tick items count time. Bytes and ticks outside a search are dropped.
//   out_if : one outcome per finished search: first found, second found or
//            timeout. The first pattern wins when both complete on one byte.
//   cfg_if : register writes (index, data), always ready; write only while idle.
// Timing:
//   An accepted item is held in the input register and processed from there;
//   its result is loaded into the output register, which offers it on out_if.
//   One item per cycle is sustained while out_if does not stall: the input
//   register is refilled in the same cycle it is processed, bounded only by
//   the single output register.
// Reset:
//   Control and config registers reset; no search is armed, both channels empty.
// Stall:
//   While a result waits on out_if, the item in the input register holds and
//   in_if.ready drops; the result holds until its transfer.
module dual_pattern_stream_matcher (
  input logic              clk,
  input logic              rst_n,
  dpsm_in_if.sink          in_if,
  dpsm_out_if.source       out_if,
  dpsm_cfg_if.sink         cfg_if
);

  // Configuration registers
  logic [dpsm_pkg::PAT_W-1:0]  first_pattern_r;
  logic [dpsm_pkg::LEN_W-1:0]  first_length_r;
  logic [dpsm_pkg::PAT_W-1:0]  second_pattern_r;
  logic [dpsm_pkg::LEN_W-1:0]  second_length_r;
  logic [dpsm_pkg::TICK_W-1:0] timeout_ticks_r;

  // Input stage
  logic                        s1_valid_r;
  logic [1:0]                  action_r;
  logic [dpsm_pkg::BYTE_W-1:0] byte_r;

  // Search state
  logic                           searching_r;
  logic                           searching_nxt;
  logic [dpsm_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [dpsm_pkg::ELAPSED_W-1:0] elapsed_nxt;
  logic [dpsm_pkg::ELAPSED_W-1:0] elapsed_inc;

  // Output register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  dpsm_pkg::outcome_t   outcome_r;
  dpsm_pkg::outcome_t   outcome_nxt;

  logic                       proc;
  logic                       is_start;
  logic                       is_byte;
  logic                       is_tick;
  logic                       hit1;
  logic                       hit2;
  logic                       timed_out;
  logic                       result;
  logic [dpsm_pkg::LEN_W-1:0] len1;
  logic [dpsm_pkg::LEN_W-1:0] len2;
  dpsm_pkg::match_ctl_t       ctl;

  assign cfg_if.ready = 1'b1;

  // Hold configuration, update on a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pattern_r  <= '0;
      first_length_r   <= dpsm_pkg::LEN_W'(1);
      second_pattern_r <= '0;
      second_length_r  <= '0;
      timeout_ticks_r  <= '1;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        dpsm_pkg::REG_FIRST_PATTERN:  first_pattern_r  <= cfg_if.data;
        dpsm_pkg::REG_FIRST_LENGTH:
          first_length_r  <= cfg_if.data[dpsm_pkg::LEN_W-1:0];
        dpsm_pkg::REG_SECOND_PATTERN: second_pattern_r <= cfg_if.data;
        dpsm_pkg::REG_SECOND_LENGTH:
          second_length_r <= cfg_if.data[dpsm_pkg::LEN_W-1:0];
        dpsm_pkg::REG_TIMEOUT_TICKS:
          timeout_ticks_r <= cfg_if.data[dpsm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Process the held item once the output register can take a result
  assign proc        = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      action_r <= in_if.action;
      byte_r   <= in_if.rx_byte;
    end
  end

  // Decode the item
  assign is_start = proc && (action_r == dpsm_pkg::ACT_START);
  assign is_byte  = proc && searching_r && (action_r == dpsm_pkg::ACT_BYTE);
  assign is_tick  = proc && searching_r && (action_r == dpsm_pkg::ACT_TICK);

  // Effective lengths: saturate, and a zero first length means one byte
  always_comb begin
    len1 = dpsm_pkg::clamp_len(first_length_r);
    if (len1 == '0) begin
      len1 = dpsm_pkg::LEN_W'(1);
    end
    len2 = dpsm_pkg::clamp_len(second_length_r);
  end

  assign ctl.step  = is_byte;
  assign ctl.clear = is_start || result;

  dpsm_tracker u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rx_byte (byte_r),
    .pattern (first_pattern_r),
    .length  (len1),
    .hit     (hit1)
  );

  dpsm_tracker u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rx_byte (byte_r),
    .pattern (second_pattern_r),
    .length  (len2),
    .hit     (hit2)
  );

  // Count ticks with saturation, flag a timeout
  always_comb begin
    elapsed_inc = (elapsed_r == '1) ? elapsed_r
                                    : elapsed_r + dpsm_pkg::ELAPSED_W'(1);
    timed_out   = is_tick && (elapsed_inc > {1'b0, timeout_ticks_r});
    result      = hit1 || hit2 || timed_out;

    elapsed_nxt = elapsed_r;
    if (is_start) begin
      elapsed_nxt = '0;
    end else if (is_tick) begin
      elapsed_nxt = elapsed_inc;
    end

    searching_nxt = searching_r;
    if (is_start) begin
      searching_nxt = 1'b1;
    end else if (result) begin
      searching_nxt = 1'b0;
    end
  end

  // Load a result, drop it on its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    outcome_nxt   = outcome_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (result) begin
      out_valid_nxt = 1'b1;
      if (hit1) begin
        outcome_nxt = dpsm_pkg::OUT_FIRST;
      end else if (hit2) begin
        outcome_nxt = dpsm_pkg::OUT_SECOND;
      end else begin
        outcome_nxt = dpsm_pkg::OUT_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      searching_r <= searching_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.outcome = outcome_r;

  // A result always ends the search
  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    result |=> !searching_r && out_valid_r)
    else $error("search still armed after a result");

  // A start arms the search with a fresh tick count
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    is_start |=> searching_r && (elapsed_r == '0))
    else $error("start did not arm a clean search");

  // A held item is not overwritten while the output is stalled
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !proc) |=> s1_valid_r && $stable(action_r) && $stable(byte_r))
    else $error("input register changed while stalled");

endmodule

// File: bench/dpsm_checker.sv
// Checker for the dual pattern stream matcher: watches the input, result and register
// channels, predicts each outcome and compares it with the block's output.
// Depends on dpsm_pkg and the channel interfaces in dpsm_ifs.
`timescale 1ns / 1ps

module dpsm_checker (
  input  logic clk,
  input  logic rst_n,
  dpsm_in_if   in_mon,
  dpsm_out_if  out_mon,
  dpsm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   live_items,
  output int   results_seen
);

  // Shadow copy of the register file
  logic [dpsm_pkg::PAT_W-1:0]     first_pat;
  logic [dpsm_pkg::LEN_W-1:0]     first_len;
  logic [dpsm_pkg::PAT_W-1:0]     second_pat;
  logic [dpsm_pkg::LEN_W-1:0]     second_len;
  logic [dpsm_pkg::TICK_W-1:0]    timeout_lim;

  // Predicted search state
  logic [dpsm_pkg::LEN_W-1:0]     first_pos;
  logic [dpsm_pkg::LEN_W-1:0]     second_pos;
  logic [dpsm_pkg::ELAPSED_W-1:0] elapsed;
  logic                           armed;

  dpsm_pkg::outcome_t             outcome_q[$];
  dpsm_pkg::outcome_t             exp_outcome;

  // Next match position of one pattern after byte b
  function automatic logic [dpsm_pkg::LEN_W-1:0] next_pos(
      input logic [dpsm_pkg::LEN_W-1:0]  pos,
      input logic [dpsm_pkg::PAT_W-1:0]  pat,
      input logic [dpsm_pkg::LEN_W-1:0]  len,
      input logic [dpsm_pkg::BYTE_W-1:0] b);
    logic [dpsm_pkg::LEN_W-1:0]  cur;
    logic [dpsm_pkg::BYTE_W-1:0] want;
    cur  = (pos >= len) ? '0 : pos;
    want = pat[cur[dpsm_pkg::POS_IDX_W-1:0]*dpsm_pkg::BYTE_W +: dpsm_pkg::BYTE_W];
    if (b == want) return cur + 1'b1;
    // on a mismatch, try the byte once more as the pattern's first byte
    if (b == pat[dpsm_pkg::BYTE_W-1:0]) return dpsm_pkg::LEN_W'(1);
    return '0;
  endfunction

  task automatic close_search(input dpsm_pkg::outcome_t res);
    outcome_q.push_back(res);
    armed      = 1'b0;
    first_pos  = '0;
    second_pos = '0;
  endtask

  task automatic write_shadow(input logic [dpsm_pkg::CFG_IDX_W-1:0]  idx,
                              input logic [dpsm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      dpsm_pkg::REG_FIRST_PATTERN:  first_pat   = data;
      dpsm_pkg::REG_FIRST_LENGTH:   first_len   = data[dpsm_pkg::LEN_W-1:0];
      dpsm_pkg::REG_SECOND_PATTERN: second_pat  = data;
      dpsm_pkg::REG_SECOND_LENGTH:  second_len  = data[dpsm_pkg::LEN_W-1:0];
      dpsm_pkg::REG_TIMEOUT_TICKS:  timeout_lim = data[dpsm_pkg::TICK_W-1:0];
      default: ;
    endcase
  endtask

  // Advance the predicted state by one accepted item
  task automatic predict_item(input logic [1:0] act, input logic [dpsm_pkg::BYTE_W-1:0] b);
    logic [dpsm_pkg::LEN_W-1:0] len1;
    logic [dpsm_pkg::LEN_W-1:0] len2;
    logic [dpsm_pkg::LEN_W-1:0] pos1;
    logic [dpsm_pkg::LEN_W-1:0] pos2;
    logic                       hit1;
    logic                       hit2;
    if (act == dpsm_pkg::ACT_START) begin
      first_pos  = '0;
      second_pos = '0;
      elapsed    = '0;
      armed      = 1'b1;
      live_items++;
    end else if (armed && act == dpsm_pkg::ACT_BYTE) begin
      live_items++;
      // saturate lengths; an empty first pattern acts as one byte
      len1 = (first_len > dpsm_pkg::LEN_W'(dpsm_pkg::MAX_PATTERN_BYTES))
           ? dpsm_pkg::LEN_W'(dpsm_pkg::MAX_PATTERN_BYTES) : first_len;
      if (len1 == '0) len1 = dpsm_pkg::LEN_W'(1);
      len2 = (second_len > dpsm_pkg::LEN_W'(dpsm_pkg::MAX_PATTERN_BYTES))
           ? dpsm_pkg::LEN_W'(dpsm_pkg::MAX_PATTERN_BYTES) : second_len;
      pos1 = next_pos(first_pos, first_pat, len1, b);
      hit1 = (pos1 >= len1);
      if (len2 != '0) begin
        pos2 = next_pos(second_pos, second_pat, len2, b);
        hit2 = (pos2 >= len2);
      end else begin
        pos2 = second_pos;
        hit2 = 1'b0;
      end
      first_pos  = pos1;
      second_pos = pos2;
      // the first pattern wins a tie
      if (hit1) close_search(dpsm_pkg::OUT_FIRST);
      else if (hit2) close_search(dpsm_pkg::OUT_SECOND);
    end else if (armed && act == dpsm_pkg::ACT_TICK) begin
      live_items++;
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      if (elapsed > {1'b0, timeout_lim}) close_search(dpsm_pkg::OUT_TIMEOUT);
    end
  endtask

  // Compare results first, then shadow register writes, then predict from the input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      first_pat    = '0;
      first_len    = dpsm_pkg::LEN_W'(1);
      second_pat   = '0;
      second_len   = '0;
      timeout_lim  = '1;
      first_pos    = '0;
      second_pos   = '0;
      elapsed      = '0;
      armed        = 1'b0;
      outcome_q.delete();
      fail_count   = 0;
      live_items   = 0;
      results_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected outcome, expected none, actual %0d",
                   $time, out_mon.outcome);
        end else begin
          exp_outcome = outcome_q.pop_front();
          if (exp_outcome != out_mon.outcome) begin
            fail_count++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, exp_outcome, out_mon.outcome);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) write_shadow(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready) predict_item(in_mon.action, in_mon.rx_byte);
    end
    pending = outcome_q.size();
  end

endmodule

// File: bench/dual_pattern_stream_matcher_tb.sv
// Testbench top for the dual pattern stream matcher: drives items, register writes and
// result back-pressure, and gives the verdict from the checker's failure count.
// Depends on dpsm_pkg, dpsm_ifs, dpsm_checker and the block itself.
`timescale 1ns / 1ps

module dual_pattern_stream_matcher_tb;

  localparam int PERIOD         = 12;
  localparam int TOTAL_ITEMS    = 550;
  localparam int IDLE_PCT       = 35;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code
  localparam logic [dpsm_pkg::CFG_IDX_W-1:0] UNUSED_REG = 3'd7;  // index with no register

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dpsm_in_if  in_if ();
  dpsm_out_if out_if ();
  dpsm_cfg_if cfg_if ();

  int fails;
  int pending;
  int live_items;
  int results_seen;

  // Stimulus control; idle_on and the hold counts are shared with the receiver
  logic idle_on       = 1'b1;
  int   hold_requests = 0;
  int   hold_served   = 0;
  int   settings_done = 0;
  int   quiet         = 0;
  int   items_sent    = 0;

  // Register values of the current setting
  logic [dpsm_pkg::PAT_W-1:0]  pat_cfg [2];
  logic [dpsm_pkg::LEN_W-1:0]  len_cfg [2];
  logic [dpsm_pkg::TICK_W-1:0] timeout_cfg;
  logic [dpsm_pkg::BYTE_W-1:0] symbols [4];

  dual_pattern_stream_matcher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  dpsm_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count   (fails),
    .pending      (pending),
    .live_items   (live_items),
    .results_seen (results_seen)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Result side: random or no back-pressure per idle_on, plus a long hold when asked
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (idle_on) begin
        out_if.ready = ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d outcomes still expected",
                 $time, quiet, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one item from a falling edge and hold it until its transfer
  task automatic send_item(input logic [1:0] act, input logic [dpsm_pkg::BYTE_W-1:0] b);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.action  = act;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [dpsm_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [dpsm_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Stop offering, wait for every expected outcome, then let the pipe empty
  task automatic settle();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all registers from the current setting; unused upper bits carry noise
  task automatic apply_setting();
    logic [dpsm_pkg::CFG_DATA_W-1:0] hi;
    settle();
    hi = {$urandom, $urandom};
    write_reg(dpsm_pkg::REG_FIRST_PATTERN, pat_cfg[0]);
    write_reg(dpsm_pkg::REG_FIRST_LENGTH,
              {hi[dpsm_pkg::CFG_DATA_W-1:dpsm_pkg::LEN_W], len_cfg[0]});
    write_reg(dpsm_pkg::REG_SECOND_PATTERN, pat_cfg[1]);
    write_reg(dpsm_pkg::REG_SECOND_LENGTH,
              {hi[dpsm_pkg::CFG_DATA_W-1:dpsm_pkg::LEN_W], len_cfg[1]});
    write_reg(dpsm_pkg::REG_TIMEOUT_TICKS,
              {hi[dpsm_pkg::CFG_DATA_W-1:dpsm_pkg::TICK_W], timeout_cfg});
    settings_done++;
  endtask

  // Mostly short patterns, now and then any length the field allows
  function automatic logic [dpsm_pkg::LEN_W-1:0] pick_len(input int floor);
    if ($urandom_range(3) == 0) return dpsm_pkg::LEN_W'($urandom_range(15));
    return dpsm_pkg::LEN_W'($urandom_range(4, floor));
  endfunction

  // One search: a start, then pattern runs, noise bytes, ticks and unused actions
  task automatic run_search();
    int                          which;
    int                          len;
    int                          k;
    logic [dpsm_pkg::BYTE_W-1:0] b;
    send_item(dpsm_pkg::ACT_START, dpsm_pkg::BYTE_W'($urandom));
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          which = (len_cfg[1] != '0 && $urandom_range(1) == 1) ? 1 : 0;
          len   = (len_cfg[which] > dpsm_pkg::MAX_PATTERN_BYTES)
                ? dpsm_pkg::MAX_PATTERN_BYTES : int'(len_cfg[which]);
          if (len == 0) len = 1;
          for (k = 0; k < len; k++) begin
            b = pat_cfg[which][k*dpsm_pkg::BYTE_W +: dpsm_pkg::BYTE_W];
            // corrupt a byte now and then
            if ($urandom_range(9) == 0) b = symbols[$urandom_range(3)];
            send_item(dpsm_pkg::ACT_BYTE, b);
          end
        end
        5, 6: begin
          repeat ($urandom_range(4, 1)) begin
            send_item(dpsm_pkg::ACT_BYTE,
                      ($urandom_range(1) == 1) ? symbols[$urandom_range(3)]
                                               : dpsm_pkg::BYTE_W'($urandom));
          end
        end
        7, 8: begin
          repeat ($urandom_range(6, 1)) begin
            send_item(dpsm_pkg::ACT_TICK, dpsm_pkg::BYTE_W'($urandom));
          end
        end
        default: send_item(ACT_NONE, dpsm_pkg::BYTE_W'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    int phase;
    int i;
    in_if.valid   = 1'b0;
    in_if.action  = dpsm_pkg::ACT_START;
    in_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = dpsm_pkg::REG_FIRST_PATTERN;
    cfg_if.data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: first pattern is one zero byte, second disabled.
    // Bytes, ticks and unused actions before a start are dropped.
    send_item(dpsm_pkg::ACT_BYTE, 8'h00);
    send_item(dpsm_pkg::ACT_TICK, 8'hFF);
    send_item(ACT_NONE, 8'h00);
    send_item(dpsm_pkg::ACT_START, 8'hFF);
    send_item(ACT_NONE, 8'h5A);
    send_item(dpsm_pkg::ACT_BYTE, 8'hFF);
    send_item(dpsm_pkg::ACT_BYTE, 8'h00);

    // Both patterns end on the same byte; the repeated 01 is re-checked as a first byte
    pat_cfg[0]  = 64'h0807_0605_0403_0201;
    len_cfg[0]  = 4'd3;
    pat_cfg[1]  = 64'hFFFF_FFFF_FFFF_0302;
    len_cfg[1]  = 4'd2;
    timeout_cfg = 32'd2;
    apply_setting();
    send_item(dpsm_pkg::ACT_START, 8'h00);
    send_item(dpsm_pkg::ACT_BYTE, 8'h01);
    send_item(dpsm_pkg::ACT_BYTE, 8'h01);
    send_item(dpsm_pkg::ACT_BYTE, 8'h02);
    send_item(dpsm_pkg::ACT_BYTE, 8'h03);
    // second pattern alone
    send_item(dpsm_pkg::ACT_START, 8'h00);
    send_item(dpsm_pkg::ACT_BYTE, 8'h02);
    send_item(dpsm_pkg::ACT_BYTE, 8'h03);
    // restart during a search, then time out
    send_item(dpsm_pkg::ACT_START, 8'h00);
    send_item(dpsm_pkg::ACT_TICK, 8'h00);
    send_item(dpsm_pkg::ACT_START, 8'hFF);
    send_item(dpsm_pkg::ACT_TICK, 8'h00);
    send_item(dpsm_pkg::ACT_TICK, 8'hFF);
    send_item(dpsm_pkg::ACT_TICK, 8'h00);

    // Oversized lengths saturate; zero timeout fails on the first tick
    pat_cfg[0]  = '1;
    len_cfg[0]  = 4'd15;
    pat_cfg[1]  = '0;
    len_cfg[1]  = 4'd9;
    timeout_cfg = '0;
    apply_setting();
    send_item(dpsm_pkg::ACT_START, 8'h00);
    send_item(dpsm_pkg::ACT_TICK, 8'h00);

    // Zero first length acts as one byte; largest timeout
    pat_cfg[0]  = 64'hA5;
    len_cfg[0]  = 4'd0;
    pat_cfg[1]  = '0;
    len_cfg[1]  = 4'd8;
    timeout_cfg = '1;
    apply_setting();
    write_reg(UNUSED_REG, {$urandom, $urandom});
    send_item(dpsm_pkg::ACT_START, 8'h00);
    send_item(dpsm_pkg::ACT_BYTE, 8'hA5);

    // Random phases: new setting each phase, a few searches per setting
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      idle_on = !(phase >= 3 && phase < 6);
      for (i = 0; i < 4; i++) symbols[i] = dpsm_pkg::BYTE_W'($urandom);
      for (i = 0; i < 2; i++) begin
        if ($urandom_range(3) == 0) begin
          pat_cfg[i] = {$urandom, $urandom};
        end else begin
          for (int j = 0; j < dpsm_pkg::MAX_PATTERN_BYTES; j++) begin
            pat_cfg[i][j*dpsm_pkg::BYTE_W +: dpsm_pkg::BYTE_W] = symbols[$urandom_range(3)];
          end
        end
      end
      len_cfg[0] = pick_len(1);
      len_cfg[1] = pick_len(0);
      case ($urandom_range(4))
        0:       timeout_cfg = '0;
        1:       timeout_cfg = '1;
        2:       timeout_cfg = dpsm_pkg::TICK_W'($urandom_range(8, 1));
        3:       timeout_cfg = dpsm_pkg::TICK_W'($urandom_range(40, 9));
        default: timeout_cfg = $urandom;
      endcase
      apply_setting();
      // hold the result side off so the block fills and stalls its input
      if (phase == 1) hold_requests++;
      repeat ($urandom_range(5, 2)) run_search();
      phase++;
    end

    settle();
    $display("sent %0d items, %0d inside searches, %0d checked outcomes", items_sent,
             live_items, results_seen);
    $display("over %0d register settings, %0d mismatches", settings_done, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: dual_pattern_stream_matcher.f
hw/rtl/dpsm_pkg.sv
hw/rtl/dpsm_ifs.sv
hw/rtl/dpsm_tracker.sv
hw/rtl/dual_pattern_stream_matcher.sv
bench/dpsm_checker.sv
bench/dual_pattern_stream_matcher_tb.sv
